@@ rtl/core/sda_pkg.sv @@
// ----------------------------------------------------------------------------
// sda_pkg
// Shared types and constants for the stack depth analyzer: item layouts,
// instruction class codes and the control bundles between submodules.
// ----------------------------------------------------------------------------
package sda_pkg;

    localparam int SIZE_W   = 11;
    localparam int TARGET_W = 32;
    localparam int OUT_W    = 11;
    localparam int OP_W     = 3;
    // tag width of the per-program generation stamp kept next to each depth
    localparam int EPOCH_W  = 8;

    localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
    localparam logic [OP_W-1:0] OP_POP     = 3'd1;
    localparam logic [OP_W-1:0] OP_NEUTRAL = 3'd2;
    localparam logic [OP_W-1:0] OP_JUMP    = 3'd3;
    localparam logic [OP_W-1:0] OP_CJUMP   = 3'd4;
    localparam logic [OP_W-1:0] OP_RETURN  = 3'd5;

    typedef struct packed {
        logic                first_item;
        logic [OP_W-1:0]     op_class;
        logic [TARGET_W-1:0] jump_target;
        logic [SIZE_W-1:0]   program_size;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] maximum_depth;
        logic             underflow_seen;
    } out_item_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_start;
    } tbl_ctl_t;

    typedef struct packed {
        logic reached;
        logic tgt_wr;
        logic fall;
        logic under;
        logic emit;
    } eval_flags_t;

endpackage

@@ rtl/core/sda_table.sv @@
// ----------------------------------------------------------------------------
// sda_table
// Entry depth table: one write port, two registered read ports. Each entry
// holds a generation tag and a depth; a sweep writes tag zero to every entry
// after reset and on request.
// ----------------------------------------------------------------------------
module sda_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11,
    parameter int EW    = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sda_pkg::tbl_ctl_t ctl,
    input  logic [AW-1:0]    rd_addr0,
    input  logic [AW-1:0]    rd_addr1,
    input  logic [AW-1:0]    wr_addr,
    input  logic [EW-1:0]    wr_tag,
    input  logic [DW-1:0]    wr_depth,
    output logic [EW-1:0]    rd_tag0,
    output logic [DW-1:0]    rd_depth0,
    output logic [EW-1:0]    rd_tag1,
    output logic             busy
);

    localparam int ENT_W = EW + DW;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd0_reg;
    // second port only needs the tag
    logic [EW-1:0]    rd1_reg;

    logic          busy_reg, busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [ENT_W-1:0] wdata;

    always_comb begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                busy_next = 1'b0;
            end
        end else if (ctl.clear_start) begin
            busy_next     = 1'b1;
            clr_addr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign we    = busy_reg || ctl.wr_en;
    assign waddr = busy_reg ? clr_addr_reg : wr_addr;
    assign wdata = busy_reg ? '0 : {wr_tag, wr_depth};

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd0_reg <= mem[rd_addr0];
            rd1_reg <= mem[rd_addr1][ENT_W-1:DW];
        end
    end

    assign rd_tag0   = rd0_reg[ENT_W-1:DW];
    assign rd_depth0 = rd0_reg[DW-1:0];
    assign rd_tag1   = rd1_reg;
    assign busy      = busy_reg;

endmodule

@@ rtl/core/sda_eval.sv @@
// ----------------------------------------------------------------------------
// sda_eval
// Execute stage datapath: resolves the entry depth of the current
// instruction, applies its class, and decides the jump target record.
// ----------------------------------------------------------------------------
module sda_eval #(
    parameter int DW = 11,
    parameter int PW = 11,
    parameter int EW = 8
) (
    input  logic [sda_pkg::OP_W-1:0]     op_class,
    input  logic                         first,
    input  logic                         run,
    input  logic [PW-1:0]                pos,
    input  logic [PW-1:0]                size,
    input  logic [sda_pkg::TARGET_W-1:0] target,
    input  logic [EW-1:0]                epoch,
    input  logic [EW-1:0]                rd_tag0,
    input  logic [DW-1:0]                rd_depth0,
    input  logic [EW-1:0]                rd_tag1,
    input  logic                         fwd_p,
    input  logic                         fwd_t,
    input  logic [DW-1:0]                fwd_depth,
    input  logic                         carry_valid,
    input  logic [DW-1:0]                carry_depth,
    input  logic [DW-1:0]                max_in,
    input  logic                         uf_in,
    output sda_pkg::eval_flags_t         flags,
    output logic [DW-1:0]                depth_out,
    output logic [DW-1:0]                max_out,
    output logic                         uf_out
);

    logic          pos_zero;
    logic          hit0;
    logic          reached;
    logic [DW-1:0] depth_in;
    logic          pops;
    logic          under;
    logic          fall;
    logic          jumps;
    logic          tgt_fwd;
    logic [DW-1:0] max_base;
    logic          uf_base;

    always_comb begin
        pos_zero = (pos == '0);
        hit0     = (rd_tag0 == epoch);
        // earlier jump records win over the fall-through of the previous item
        reached  = pos_zero || fwd_p || hit0 || carry_valid;
        if (pos_zero) begin
            depth_in = '0;
        end else if (fwd_p) begin
            depth_in = fwd_depth;
        end else if (hit0) begin
            depth_in = rd_depth0;
        end else begin
            depth_in = carry_depth;
        end

        pops  = 1'b0;
        fall  = 1'b1;
        jumps = 1'b0;
        case (op_class)
            sda_pkg::OP_PUSH:    ;
            sda_pkg::OP_POP:     pops = 1'b1;
            sda_pkg::OP_NEUTRAL: ;
            sda_pkg::OP_JUMP: begin
                fall  = 1'b0;
                jumps = 1'b1;
            end
            sda_pkg::OP_CJUMP: begin
                pops  = 1'b1;
                jumps = 1'b1;
            end
            sda_pkg::OP_RETURN: begin
                pops = 1'b1;
                fall = 1'b0;
            end
            default: ;
        endcase

        under = pops && (depth_in == '0);
        if (op_class == sda_pkg::OP_PUSH) begin
            depth_out = depth_in + 1'b1;
        end else if (pops && !under) begin
            depth_out = depth_in - 1'b1;
        end else begin
            depth_out = depth_in;
        end

        // backward targets are never read again in this program: skip them
        tgt_fwd = (target > sda_pkg::TARGET_W'(pos)) &&
                  (target < sda_pkg::TARGET_W'(size));

        max_base = first ? '0 : max_in;
        uf_base  = first ? 1'b0 : uf_in;
        max_out  = max_base;
        uf_out   = uf_base;
        if (run && reached) begin
            if (depth_out > max_base) begin
                max_out = depth_out;
            end
            uf_out = uf_base | under;
        end

        flags.reached = run && reached;
        flags.tgt_wr  = run && reached && jumps && tgt_fwd && !(fwd_t || rd_tag1 == epoch);
        flags.fall    = run && reached && fall;
        flags.under   = run && reached && under;
        flags.emit    = run && (PW'(pos + 1'b1) == size);
    end

endmodule

@@ rtl/core/stack_depth_analyzer.sv @@
// ----------------------------------------------------------------------------
// stack_depth_analyzer
// Maximum stack depth of a stack-machine program in one forward pass.
// ----------------------------------------------------------------------------
// Takes one classified instruction per cycle in program order and reports the
// maximum depth and an underflow flag on the last instruction of a program.
// Two stages: the accept cycle reads the entry depth table at the current
// index and at the jump target; the next cycle applies the class, records the
// jump target depth and forwards the fall-through depth to the next item, so
// items flow back to back. Besides the tag sweep, only a result the sink has
// not yet taken, with a second one ready to leave, stalls the input. Each
// table entry carries a program generation tag instead of a reached bit; after
// reset, and before every 255th program start, a sweep clears the tags of all
// MAX_INSTRUCTIONS entries and holds s_ready low.
module stack_depth_analyzer #(
    parameter int MAX_INSTRUCTIONS = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sda_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sda_pkg::out_item_t m_data
);

    localparam int AW = $clog2(MAX_INSTRUCTIONS);
    localparam int PW = $clog2(MAX_INSTRUCTIONS + 1);
    localparam int DW = PW;
    localparam int CW = (PW > sda_pkg::SIZE_W) ? PW : sda_pkg::SIZE_W;
    localparam int EW = sda_pkg::EPOCH_W;

    // accept stage
    logic          acc;
    logic [PW-1:0] size_a;
    logic [CW-1:0] size_ext;
    logic [PW-1:0] p_a;
    logic          run_a;
    logic          wrap_hold;
    logic          wrap_start;
    logic          busy;

    logic [PW-1:0] pos_reg, pos_next;
    logic [EW-1:0] epoch_reg, epoch_next;

    // execute stage
    logic                         b_valid_reg, b_valid_next;
    logic                         b_first_reg;
    logic                         b_run_reg;
    logic [sda_pkg::OP_W-1:0]     b_op_reg;
    logic [sda_pkg::TARGET_W-1:0] b_tgt_reg;
    logic [PW-1:0]                b_size_reg;
    logic [PW-1:0]                b_pos_reg;
    logic                         b_fwd_p_reg;
    logic                         b_fwd_t_reg;
    logic [DW-1:0]                b_fwd_depth_reg;

    logic          carry_valid_reg;
    logic [DW-1:0] carry_depth_reg;
    logic [DW-1:0] max_reg;
    logic          uf_reg;

    logic          m_valid_reg, m_valid_next;
    sda_pkg::out_item_t m_data_reg;

    sda_pkg::tbl_ctl_t    tctl;
    sda_pkg::eval_flags_t flags;
    logic [EW-1:0] rd_tag0, rd_tag1;
    logic [DW-1:0] rd_depth0;
    logic [DW-1:0] depth_out, max_out;
    logic          uf_out;
    logic          stall;
    logic          b_fire;
    logic          wr_en;

    // ---- accept stage -------------------------------------------------------
    always_comb begin
        size_ext = CW'(s_data.program_size);
        if (size_ext == '0) begin
            size_a = PW'(1);
        end else if (size_ext > CW'(MAX_INSTRUCTIONS)) begin
            size_a = PW'(MAX_INSTRUCTIONS);
        end else begin
            size_a = size_ext[PW-1:0];
        end
    end

    assign p_a   = s_data.first_item ? '0 : pos_reg;
    assign run_a = (p_a < size_a);

    assign stall      = b_valid_reg && flags.emit && m_valid_reg && !m_ready;
    assign b_fire     = b_valid_reg && !stall;
    assign wr_en      = b_fire && flags.tgt_wr;
    // the last generation value must not be reused before a sweep
    assign wrap_hold  = s_valid && s_data.first_item && (epoch_reg == '1);
    assign wrap_start = wrap_hold && !b_valid_reg && !busy;
    assign s_ready    = !busy && !stall && !wrap_hold;
    assign acc        = s_valid && s_ready;

    always_comb begin
        pos_next   = pos_reg;
        epoch_next = epoch_reg;
        if (wrap_start) begin
            epoch_next = '0;
        end
        if (acc) begin
            pos_next = run_a ? PW'(p_a + 1'b1) : p_a;
            if (s_data.first_item) begin
                epoch_next = epoch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            epoch_reg <= EW'(1);
        end else begin
            pos_reg   <= pos_next;
            epoch_reg <= epoch_next;
        end
    end

    assign tctl.rd_en       = acc;
    assign tctl.wr_en       = wr_en;
    assign tctl.clear_start = wrap_start;

    sda_table #(
        .DEPTH (MAX_INSTRUCTIONS),
        .AW    (AW),
        .DW    (DW),
        .EW    (EW)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (tctl),
        .rd_addr0  (p_a[AW-1:0]),
        .rd_addr1  (s_data.jump_target[AW-1:0]),
        .wr_addr   (b_tgt_reg[AW-1:0]),
        .wr_tag    (epoch_reg),
        .wr_depth  (depth_out),
        .rd_tag0   (rd_tag0),
        .rd_depth0 (rd_depth0),
        .rd_tag1   (rd_tag1),
        .busy      (busy)
    );

    // ---- execute stage ------------------------------------------------------
    assign b_valid_next = acc ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    // capture the write landing in the same cycle as the table read
    always_ff @(posedge aclk) begin
        if (acc) begin
            b_first_reg     <= s_data.first_item;
            b_run_reg       <= run_a;
            b_op_reg        <= s_data.op_class;
            b_tgt_reg       <= s_data.jump_target;
            b_size_reg      <= size_a;
            b_pos_reg       <= p_a;
            b_fwd_p_reg     <= wr_en && !s_data.first_item && (b_tgt_reg[AW-1:0] == p_a[AW-1:0]);
            b_fwd_t_reg     <= wr_en && !s_data.first_item &&
                               (b_tgt_reg[AW-1:0] == s_data.jump_target[AW-1:0]);
            b_fwd_depth_reg <= depth_out;
        end
    end

    sda_eval #(
        .DW (DW),
        .PW (PW),
        .EW (EW)
    ) u_eval (
        .op_class    (b_op_reg),
        .first       (b_first_reg),
        .run         (b_run_reg),
        .pos         (b_pos_reg),
        .size        (b_size_reg),
        .target      (b_tgt_reg),
        .epoch       (epoch_reg),
        .rd_tag0     (rd_tag0),
        .rd_depth0   (rd_depth0),
        .rd_tag1     (rd_tag1),
        .fwd_p       (b_fwd_p_reg),
        .fwd_t       (b_fwd_t_reg),
        .fwd_depth   (b_fwd_depth_reg),
        .carry_valid (carry_valid_reg),
        .carry_depth (carry_depth_reg),
        .max_in      (max_reg),
        .uf_in       (uf_reg),
        .flags       (flags),
        .depth_out   (depth_out),
        .max_out     (max_out),
        .uf_out      (uf_out)
    );

    // items past the end leave the carried fall-through untouched; the last
    // item of a program carries nothing forward
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_valid_reg <= 1'b0;
            max_reg         <= '0;
            uf_reg          <= 1'b0;
        end else if (b_fire && b_run_reg) begin
            carry_valid_reg <= flags.fall && !flags.emit;
            max_reg         <= max_out;
            uf_reg          <= uf_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire && b_run_reg) begin
            carry_depth_reg <= depth_out;
        end
    end

    // ---- result register ----------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (b_fire && flags.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire && flags.emit) begin
            m_data_reg.maximum_depth  <= sda_pkg::OUT_W'(max_out);
            m_data_reg.underflow_seen <= uf_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---- assertions ---------------------------------------------------------
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> b_valid_reg && $stable(b_pos_reg))
        else $error("stalled item left the execute stage");

    a_write_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (b_tgt_reg > sda_pkg::TARGET_W'(b_pos_reg)) &&
                  (b_tgt_reg < sda_pkg::TARGET_W'(b_size_reg)))
        else $error("table write outside the forward program range");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(b_valid_reg))
        else $error("result without an executed item");

    a_live_epoch: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> epoch_reg != '0)
        else $error("item executed under the cleared generation tag");

    a_no_sweep_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !b_valid_reg && !wr_en)
        else $error("table sweep overlaps an item");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PW'(MAX_INSTRUCTIONS))
        else $error("position beyond table depth");

endmodule
